FILE: sv/dro_pkg.sv
`default_nettype none
package dro_pkg;
    localparam int CordicMax = 30;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] RAD_TO_BAM      = 32'd1367130551;
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/dead_reckoning_odometry.sv
`default_nettype none
// dead-reckoning pose integrator, unicycle model, forward euler
// slave channel: s_axis_tuser = kind (0 command, 1 tick); s_axis_tdata carries
//   cmd_speed [15:0], cmd_turn [31:16], tick_dt [47:32]
// a command transfer updates the held speed/turn (rejected if |speed| exceeds
//   twice speed_limit) and yields no result; a tick with dt = 0 is dropped
// a tick with nonzero dt runs one step and yields one master transfer:
//   pose_x, pose_y, heading, quat_z, quat_w, speed_echo, turn_echo
// the step uses one shift-add multiplier and one cordic, both one bit per cycle:
//   cordic on the heading, two 2-stage products for x and y (S_MULA then S_MULB,
//   each followed by an add in S_POS), heading product (S_HMA then S_HMB,
//   followed by an add in S_HADD), half-angle cordic (S_COR2)
// a tick result becomes valid as the block turns ready again; a command is taken
//   in idle and the block stays ready for the next item
// the result sits in an output register; the next item is accepted as soon as
//   the step finishes, while an earlier result may still wait for m_axis_tready
//   (a new tick waits for that register to drain before its result is written)
// user writes speed_limit via cfg_we/cfg_data only when idle; not enforced
// reset clears the pose, heading and held velocities and sets speed_limit 2048
module dead_reckoning_odometry
    import dro_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [13:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd_speed [15:0], cmd_turn [31:16], tick_dt [47:32]
    input  wire logic [47:0] s_axis_tdata,
    // kind
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pose_x, pose_y, heading, quat_z, quat_w, speed_echo, turn_echo
    output logic [159:0]     m_axis_tdata
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_COR1 = 4'd1, S_MULA = 4'd2,
                           S_MULB = 4'd3, S_POS = 4'd4, S_HMA = 4'd5,
                           S_HMB = 4'd6, S_HADD = 4'd7, S_COR2 = 4'd8,
                           S_OUT = 4'd9;

    logic [3:0]  state_reg;
    logic [13:0] limit_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [31:0] hd_reg;
    logic signed [15:0] spd_reg, trn_reg;
    logic [15:0] dt_reg;
    logic        axis_reg;   // 0 x pass, 1 y pass
    // cordic
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic        flip_reg;
    logic [SW-1:0] it_reg;
    // bit-serial multiplier: acc += mcand when multiplier lsb set, shifted
    logic signed [79:0] acc_reg;
    logic signed [79:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [5:0]  bit_reg;
    logic signed [33:0] cres_reg, sres_reg;
    logic        ovalid_reg;
    logic [159:0] odata_reg;

    // start cordic on a binary angle
    logic [31:0] ang_w;
    logic        need_flip_w;
    logic [31:0] ang_adj_w;
    logic signed [33:0] cx_sh, cy_sh;
    logic        zneg;
    logic signed [33:0] atan_w;

    always_comb
    begin
        need_flip_w = ($signed(ang_w) >= 32'sh40000000) || ($signed(ang_w) < -32'sh40000000);
        ang_adj_w   = need_flip_w ? ang_w - 32'h80000000 : ang_w;
        cx_sh = cx_reg >>> it_reg;
        cy_sh = cy_reg >>> it_reg;
        zneg  = cz_reg[33];
        atan_w = {2'b00, atan_entry(5'(it_reg))};
    end

    logic signed [33:0] xsum_w;
    logic signed [63:0] dpos_w;
    logic signed [31:0] dth_w;
    logic [31:0] hd_next;
    logic signed [15:0] cmd_speed, cmd_turn;
    logic [15:0] av_w;
    logic signed [33:0] qz_w, qw_w;

    function automatic logic [15:0] to_q15(input logic signed [33:0] r);
        logic signed [33:0] q;
        begin
            q = (r + 34'sd16384) >>> 15;
            if (q > 34'sd32767) return 16'h7FFF;
            else if (q < -34'sd32768) return 16'h8000;
            else return q[15:0];
        end
    endfunction

    always_comb
    begin
        cmd_speed = s_axis_tdata[15:0];
        cmd_turn  = s_axis_tdata[31:16];
        av_w      = cmd_speed[15] ? 16'(-cmd_speed) : cmd_speed;
        // position step: floor((p + 2^41) / 2^42)
        dpos_w = 64'((acc_reg + 80'sd2199023255552) >>> 42);
        xsum_w = (axis_reg ? {{2{py_reg[31]}}, py_reg} : {{2{px_reg[31]}}, px_reg})
                 + {{2{dpos_w[31]}}, dpos_w[31:0]};
        dth_w  = 32'((acc_reg + 80'sd268435456) >>> 29);
        hd_next = hd_reg + dth_w;
        ang_w  = (state_reg == S_HADD) ? {hd_next[31], hd_next[31:1]} : hd_reg;
        qz_w = flip_reg ? -cy_reg : cy_reg;
        qw_w = flip_reg ? -cx_reg : cx_reg;
    end

    logic pos_big, pos_small;
    always_comb
    begin
        pos_big   = (dpos_w > 64'sd2147483647) ||
                    (xsum_w > 34'sd2147483647);
        pos_small = (dpos_w < -64'sd2147483648) ||
                    (xsum_w < -34'sd2147483648);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= 14'd2048;
            px_reg     <= '0;
            py_reg     <= '0;
            hd_reg     <= '0;
            spd_reg    <= '0;
            trn_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            // in S_OUT the valid flag is handled by the output write below
            if (ovalid_reg && m_axis_tready && state_reg != S_OUT)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser == KIND_CMD)
                        begin
                            if ({1'b0, av_w} <= {2'b00, limit_reg, 1'b0})
                            begin
                                spd_reg <= cmd_speed;
                                trn_reg <= cmd_turn;
                            end
                        end
                        else if (s_axis_tdata[47:32] != 16'd0)
                        begin
                            dt_reg   <= s_axis_tdata[47:32];
                            state_reg <= S_COR1;
                            cx_reg   <= {2'b00, CORDIC_GAIN_Q30};
                            cy_reg   <= '0;
                            cz_reg   <= {{2{ang_adj_w[31]}}, ang_adj_w};
                            flip_reg <= need_flip_w;
                            it_reg   <= '0;
                        end
                    end
                end
                S_COR1, S_COR2:
                begin
                    if (it_reg == SW'(CORDIC_STEPS))
                    begin
                        if (state_reg == S_COR1)
                        begin
                            cres_reg <= qw_w;
                            sres_reg <= qz_w;
                            axis_reg <= 1'b0;
                            state_reg <= S_MULA;
                            acc_reg <= '0;
                            mcand_reg <= 80'(spd_reg);
                            mplier_reg <= {16'd0, dt_reg};
                            bit_reg <= '0;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (!zneg)
                        begin
                            cx_reg <= cx_reg - cy_sh;
                            cy_reg <= cy_reg + cx_sh;
                            cz_reg <= cz_reg - atan_w;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + cy_sh;
                            cy_reg <= cy_reg - cx_sh;
                            cz_reg <= cz_reg + atan_w;
                        end
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_MULA, S_HMA:
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + (mcand_reg <<< bit_reg);
                    mplier_reg <= mplier_reg >> 1;
                    if (bit_reg == 6'd15)
                    begin
                        state_reg <= (state_reg == S_MULA) ? S_MULB : S_HMB;
                        bit_reg <= '0;
                    end
                    else
                        bit_reg <= bit_reg + 1'b1;
                end
                S_MULB, S_HMB:
                begin
                    if (bit_reg == 6'd0)
                    begin
                        // second stage: product so far times constant or c/s
                        mcand_reg <= acc_reg;
                        acc_reg <= '0;
                        mplier_reg <= (state_reg == S_HMB) ? RAD_TO_BAM :
                                      (axis_reg ? sres_reg[31:0] : cres_reg[31:0]);
                        bit_reg <= 6'd1;
                    end
                    else
                    begin
                        // signed multiplier in S_MULB: top bit weighs -2^31
                        if (mplier_reg[0])
                        begin
                            if (bit_reg == 6'd32 && state_reg == S_MULB)
                                acc_reg <= acc_reg - (mcand_reg <<< 31);
                            else
                                acc_reg <= acc_reg + (mcand_reg <<< (bit_reg - 6'd1));
                        end
                        mplier_reg <= mplier_reg >> 1;
                        if (bit_reg == 6'd32)
                            state_reg <= (state_reg == S_MULB) ? S_POS : S_HADD;
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                S_POS:
                begin
                    if (axis_reg)
                        py_reg <= pos_big ? 32'sh7FFFFFFF : pos_small ? 32'sh80000000
                                  : xsum_w[31:0];
                    else
                        px_reg <= pos_big ? 32'sh7FFFFFFF : pos_small ? 32'sh80000000
                                  : xsum_w[31:0];
                    acc_reg <= '0;
                    bit_reg <= '0;
                    if (axis_reg)
                    begin
                        state_reg <= S_HMA;
                        mcand_reg <= 80'(trn_reg);
                        mplier_reg <= {16'd0, dt_reg};
                    end
                    else
                    begin
                        axis_reg <= 1'b1;
                        state_reg <= S_MULA;
                        mcand_reg <= 80'(spd_reg);
                        mplier_reg <= {16'd0, dt_reg};
                    end
                end
                S_HADD:
                begin
                    hd_reg   <= hd_next;
                    cx_reg   <= {2'b00, CORDIC_GAIN_Q30};
                    cy_reg   <= '0;
                    cz_reg   <= {{2{ang_adj_w[31]}}, ang_adj_w};
                    flip_reg <= need_flip_w;
                    it_reg   <= '0;
                    state_reg <= S_COR2;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        odata_reg <= {trn_reg, spd_reg, to_q15(qw_w), to_q15(qz_w),
                                      hd_reg, py_reg, px_reg};
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    a_cmd_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (state_reg == S_IDLE))
        else $error("command started a step");
endmodule
`default_nettype wire
